// File: sv/fls_pkg.sv
// Shared constants, types and register codes for the flat Lambert shader.
package fls_pkg;

  // Vertex coordinate width; edges are narrowed when they would pass 31 bits.
  localparam int COORD_BITS = 16;
  localparam int EDGE_SHIFT = (COORD_BITS + 1 > 31) ? (COORD_BITS + 1 - 31) : 0;
  localparam int EDGE_W     = COORD_BITS + 1 - EDGE_SHIFT;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int MAG_W      = CROSS_W;
  localparam int SHIFT_W    = $clog2(MAG_W);

  // Normalization and fixed point.
  localparam int NORM_TOP  = 19;
  localparam int FRAC_BITS = 14;
  localparam int LIGHT_W   = 16;
  localparam int COLOR_W   = 8;
  localparam int SCM_W     = NORM_TOP + 1;          // scaled magnitude
  localparam int SC_W      = SCM_W + 1;             // scaled signed component
  localparam int SQ_W      = 2 * SCM_W + 2;         // sum of squares
  localparam int DP_W      = SC_W + LIGHT_W;        // one dot term
  localparam int DOT_W     = DP_W + 2;              // dot product sum
  localparam int DIVD_W    = DOT_W - 1;             // positive dot product

  // Square root unit: root bits per stage.
  localparam int SQRT_PER_STG = 3;
  localparam int ROOT_W       = SQ_W / 2 + SQ_W % 2;
  localparam int SQRT_STAGES  = (ROOT_W + SQRT_PER_STG - 1) / SQRT_PER_STG;
  localparam int ROOT_PAD     = SQRT_STAGES * SQRT_PER_STG;
  localparam int SQ_PAD       = 2 * ROOT_PAD;
  localparam int LEN_W        = ROOT_PAD;

  // Divider: quotient bits per stage.
  localparam int DIV_PER_STG = 2;
  localparam int DIV_STAGES  = (DIVD_W - NORM_TOP + DIV_PER_STG - 1) / DIV_PER_STG;
  localparam int Q_W         = DIV_STAGES * DIV_PER_STG;

  localparam int NORM_STAGES  = 7;
  localparam int SHADE_STAGES = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_X    = 3'd0,
    CFG_LIGHT_Y    = 3'd1,
    CFG_LIGHT_Z    = 3'd2,
    CFG_BASE_RED   = 3'd3,
    CFG_BASE_GREEN = 3'd4,
    CFG_BASE_BLUE  = 3'd5,
    CFG_AMBIENT    = 3'd6
  } cfg_reg_e;

  localparam logic signed [LIGHT_W-1:0] LIGHT_X_RST = 16'sd0;
  localparam logic signed [LIGHT_W-1:0] LIGHT_Y_RST = 16'sd0;
  localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST = 16'sd16384;
  localparam logic [COLOR_W-1:0]        BASE_RST    = 8'd100;
  localparam logic [COLOR_W-1:0]        AMBIENT_RST = 8'd30;
  localparam logic [COLOR_W-1:0]        COLOR_MAX   = 8'd255;

  typedef struct packed {
    logic signed [LIGHT_W-1:0] x;
    logic signed [LIGHT_W-1:0] y;
    logic signed [LIGHT_W-1:0] z;
  } light_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] ambient;
  } color_t;

  // Pipeline control between units.
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

// File: sv/flat_lambert_triangle_shader.sv
// Pipeline of 7 geometry, 7 square root, 10 divide and 2 shade stages from input request
// to result; one triangle accepted per cycle when unstalled.
// Rate is set by the fully pipelined root and divide units, one stage per step group.
// A stalled output freezes every stage; nothing is dropped or repeated.
// Reset clears all valid bits and loads the light, base and ambient defaults.
module flat_lambert_triangle_shader import fls_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z from bit 0 up
  input  logic [9*COORD_BITS-1:0] s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // out_red, out_green, out_blue from bit 0 up
  output logic [3*COLOR_W-1:0]  m_axis_tdata_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  light_t    light_q;
  color_t    color_q;
  logic      pipe_adv;
  pipe_ctl_t ctl_norm, ctl_sqrt, ctl_div, ctl_shade;

  logic signed [COORD_BITS-1:0] vert [9];
  logic                    n_valid, n_zero;
  logic [SQ_W-1:0]         n_sq;
  logic signed [DOT_W-1:0] n_dot;
  logic                    r_valid, r_pos;
  logic [DIVD_W-1:0]       r_num;
  logic [LEN_W-1:0]        r_len;
  logic                    d_valid;
  logic [Q_W-1:0]          d_inten;
  logic                    o_valid;
  logic [COLOR_W-1:0]      rgb [3];

  // Configuration registers; writes always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q.x       <= LIGHT_X_RST;
      light_q.y       <= LIGHT_Y_RST;
      light_q.z       <= LIGHT_Z_RST;
      color_q.red     <= BASE_RST;
      color_q.green   <= BASE_RST;
      color_q.blue    <= BASE_RST;
      color_q.ambient <= AMBIENT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_LIGHT_X:    light_q.x       <= cfg_data_i;
        CFG_LIGHT_Y:    light_q.y       <= cfg_data_i;
        CFG_LIGHT_Z:    light_q.z       <= cfg_data_i;
        CFG_BASE_RED:   color_q.red     <= cfg_data_i[COLOR_W-1:0];
        CFG_BASE_GREEN: color_q.green   <= cfg_data_i[COLOR_W-1:0];
        CFG_BASE_BLUE:  color_q.blue    <= cfg_data_i[COLOR_W-1:0];
        CFG_AMBIENT:    color_q.ambient <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipe moves when the output register is free or being taken.
  assign pipe_adv        = !o_valid || m_axis_tready_i;
  assign s_axis_tready_o = pipe_adv;

  for (genvar i = 0; i < 9; i++) begin : g_vert
    assign vert[i] = s_axis_tdata_i[i*COORD_BITS +: COORD_BITS];
  end

  assign ctl_norm  = '{en: pipe_adv, valid: s_axis_tvalid_i};
  assign ctl_sqrt  = '{en: pipe_adv, valid: n_valid};
  assign ctl_div   = '{en: pipe_adv, valid: r_valid};
  assign ctl_shade = '{en: pipe_adv, valid: d_valid};

  fls_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_norm),
    .vert_i  (vert),
    .light_i (light_q),
    .valid_o (n_valid),
    .zero_o  (n_zero),
    .sq_o    (n_sq),
    .dot_o   (n_dot)
  );

  fls_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_sqrt),
    .zero_i  (n_zero),
    .sq_i    (n_sq),
    .dot_i   (n_dot),
    .valid_o (r_valid),
    .pos_o   (r_pos),
    .num_o   (r_num),
    .len_o   (r_len)
  );

  fls_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_div),
    .pos_i   (r_pos),
    .num_i   (r_num),
    .len_i   (r_len),
    .valid_o (d_valid),
    .inten_o (d_inten)
  );

  fls_shade u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_shade),
    .inten_i (d_inten),
    .color_i (color_q),
    .valid_o (o_valid),
    .rgb_o   (rgb)
  );

  assign m_axis_tvalid_o = o_valid;
  assign m_axis_tdata_o  = {rgb[2], rgb[1], rgb[0]};

`ifndef SYNTH
  // A lit face always has a normalized length of at least 2^NORM_TOP.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_valid && r_pos) |-> ((r_len >> NORM_TOP) != '0))
    else $error("normal length below normalization floor");

  // Stalled pipe holds the divider result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pipe_adv && d_valid) |=> $stable(d_inten))
    else $error("intensity changed during stall");

  // Every channel includes the ambient term.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (rgb[0] >= color_q.ambient && rgb[1] >= color_q.ambient
                         && rgb[2] >= color_q.ambient))
    else $error("channel below ambient level");
`endif

endmodule

// File: sv/fls_norm.sv
// Edges, cross product, normalizing shift, squares and light dot product.
module fls_norm import fls_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pipe_ctl_t                ctl_i,
  input  logic signed [COORD_BITS-1:0] vert_i [9],
  input  light_t                   light_i,
  output logic                     valid_o,
  output logic                     zero_o,
  output logic [SQ_W-1:0]          sq_o,
  output logic signed [DOT_W-1:0]  dot_o
);

  // Sign-magnitude narrowing of an edge, truncating toward zero.
  function automatic logic signed [EDGE_W-1:0] edge_fn(logic signed [COORD_BITS:0] x);
    logic [COORD_BITS:0] mag;
    logic [COORD_BITS:0] mag_s;
    mag   = x[COORD_BITS] ? (COORD_BITS+1)'(-x) : (COORD_BITS+1)'(x);
    mag_s = mag >> EDGE_SHIFT;
    return x[COORD_BITS] ? EDGE_W'(-mag_s) : EDGE_W'(mag_s);
  endfunction

  logic [NORM_STAGES-1:0] v_q;
  // Degenerate flag exists from stage 4 on.
  logic [NORM_STAGES-4:0] z_q;

  logic signed [EDGE_W-1:0]  e1_q [3];
  logic signed [EDGE_W-1:0]  e2_q [3];
  logic signed [PROD_W-1:0]  p_q  [6];
  logic [MAG_W-1:0]          m3_q [3];
  logic [2:0]                s3_q;
  logic [MAG_W-1:0]          m4_q [3];
  logic [2:0]                s4_q;
  logic [SHIFT_W-1:0]        pos4_q;
  logic signed [SC_W-1:0]    sc5_q  [3];
  logic [SCM_W-1:0]          scm5_q [3];
  logic [2*SCM_W-1:0]        sqr6_q [3];
  logic signed [DP_W-1:0]    dp6_q  [3];
  logic [SQ_W-1:0]           sq7_q;
  logic signed [DOT_W-1:0]   dot7_q;

  logic signed [EDGE_W-1:0]  e1_d [3];
  logic signed [EDGE_W-1:0]  e2_d [3];
  logic [MAG_W-1:0]          m3_d [3];
  logic [2:0]                s3_d;
  logic [MAG_W-1:0]          mmax_d;
  logic [SHIFT_W-1:0]        pos4_d;
  logic [SCM_W-1:0]          scm5_d [3];
  logic signed [LIGHT_W-1:0] lv [3];

  assign lv[0] = light_i.x;
  assign lv[1] = light_i.y;
  assign lv[2] = light_i.z;

  // Valid and degenerate flags travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      z_q <= '0;
    end else if (ctl_i.en) begin
      v_q <= {v_q[NORM_STAGES-2:0], ctl_i.valid};
      z_q <= {z_q[NORM_STAGES-5:0], (mmax_d == '0)};
    end
  end

  // Stage 1: edges.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_d[i] = edge_fn((COORD_BITS+1)'(vert_i[3+i]) - (COORD_BITS+1)'(vert_i[i]));
      e2_d[i] = edge_fn((COORD_BITS+1)'(vert_i[6+i]) - (COORD_BITS+1)'(vert_i[i]));
    end
  end

  // Stage 3: cross components as sign and magnitude.
  always_comb begin
    logic signed [CROSS_W-1:0] c;
    for (int k = 0; k < 3; k++) begin
      c       = CROSS_W'(p_q[2*k]) - CROSS_W'(p_q[2*k+1]);
      s3_d[k] = c[CROSS_W-1];
      m3_d[k] = c[CROSS_W-1] ? MAG_W'(-c) : MAG_W'(c);
    end
  end

  // Stage 4: largest magnitude and its leading one.
  always_comb begin
    mmax_d = m3_q[0];
    if (m3_q[1] > mmax_d) mmax_d = m3_q[1];
    if (m3_q[2] > mmax_d) mmax_d = m3_q[2];
    pos4_d = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mmax_d[b]) pos4_d = SHIFT_W'(b);
    end
  end

  // Stage 5: scale so the largest magnitude lands in [2^NORM_TOP, 2^(NORM_TOP+1)).
  always_comb begin
    logic [MAG_W+NORM_TOP-1:0] wide;
    for (int k = 0; k < 3; k++) begin
      wide      = {m4_q[k], {NORM_TOP{1'b0}}};
      scm5_d[k] = SCM_W'(wide >> pos4_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= e1_d[i];
        e2_q[i] <= e2_d[i];
      end
      // Stage 2: cross-product terms.
      p_q[0] <= e1_q[1] * e2_q[2];
      p_q[1] <= e1_q[2] * e2_q[1];
      p_q[2] <= e1_q[2] * e2_q[0];
      p_q[3] <= e1_q[0] * e2_q[2];
      p_q[4] <= e1_q[0] * e2_q[1];
      p_q[5] <= e1_q[1] * e2_q[0];
      s3_q   <= s3_d;
      s4_q   <= s3_q;
      pos4_q <= pos4_d;
      for (int k = 0; k < 3; k++) begin
        m3_q[k]   <= m3_d[k];
        m4_q[k]   <= m3_q[k];
        scm5_q[k] <= scm5_d[k];
        sc5_q[k]  <= s4_q[k] ? -SC_W'(scm5_d[k]) : SC_W'(scm5_d[k]);
        // Stage 6: squares and light terms.
        sqr6_q[k] <= scm5_q[k] * scm5_q[k];
        dp6_q[k]  <= sc5_q[k] * lv[k];
      end
      // Stage 7: sums.
      sq7_q  <= SQ_W'(sqr6_q[0]) + SQ_W'(sqr6_q[1]) + SQ_W'(sqr6_q[2]);
      dot7_q <= DOT_W'(dp6_q[0]) + DOT_W'(dp6_q[1]) + DOT_W'(dp6_q[2]);
    end
  end

  assign valid_o = v_q[NORM_STAGES-1];
  assign zero_o  = z_q[NORM_STAGES-4];
  assign sq_o    = sq7_q;
  assign dot_o   = dot7_q;

endmodule

// File: sv/fls_sqrt.sv
// Pipelined digit-by-digit integer square root, several root bits per stage.
module fls_sqrt import fls_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pipe_ctl_t               ctl_i,
  input  logic                    zero_i,
  input  logic [SQ_W-1:0]         sq_i,
  input  logic signed [DOT_W-1:0] dot_i,
  output logic                    valid_o,
  output logic                    pos_o,
  output logic [DIVD_W-1:0]       num_o,
  output logic [LEN_W-1:0]        len_o
);

  localparam int REM_W = ROOT_PAD + 3;

  typedef struct packed {
    logic [SQ_PAD-1:0]   rad;
    logic [REM_W-1:0]    rem;
    logic [ROOT_PAD-1:0] root;
  } sqst_t;

  // One restoring step: bring down two radicand bits, try root*4+1.
  function automatic sqst_t sq_step(sqst_t a);
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] tr;
    sqst_t            b;
    r2    = {a.rem[REM_W-3:0], a.rad[SQ_PAD-1 -: 2]};
    tr    = REM_W'({a.root, 2'b01});
    b.rad = a.rad << 2;
    if (r2 >= tr) begin
      b.rem  = r2 - tr;
      b.root = {a.root[ROOT_PAD-2:0], 1'b1};
    end else begin
      b.rem  = r2;
      b.root = {a.root[ROOT_PAD-2:0], 1'b0};
    end
    return b;
  endfunction

  logic [SQRT_STAGES-1:0] v_q;
  logic [SQRT_STAGES-1:0] pos_q;
  logic [DIVD_W-1:0]      num_q [SQRT_STAGES];
  sqst_t                  st_q  [SQRT_STAGES];
  sqst_t                  st_d  [SQRT_STAGES];
  sqst_t                  init;
  logic                   pos_in;

  // Only a positive dot product on a real triangle lights the face.
  assign pos_in    = !zero_i && !dot_i[DOT_W-1] && (dot_i != '0);
  assign init.rad  = SQ_PAD'(sq_i);
  assign init.rem  = '0;
  assign init.root = '0;

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stg
    always_comb begin
      sqst_t t;
      t = (s == 0) ? init : st_q[(s == 0) ? 0 : s-1];
      for (int j = 0; j < SQRT_PER_STG; j++) begin
        t = sq_step(t);
      end
      st_d[s] = t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      pos_q <= '0;
    end else if (ctl_i.en) begin
      v_q   <= {v_q[SQRT_STAGES-2:0], ctl_i.valid};
      pos_q <= {pos_q[SQRT_STAGES-2:0], pos_in};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      num_q[0] <= DIVD_W'(dot_i);
      st_q[0]  <= st_d[0];
      for (int s = 1; s < SQRT_STAGES; s++) begin
        num_q[s] <= num_q[s-1];
        st_q[s]  <= st_d[s];
      end
    end
  end

  assign valid_o = v_q[SQRT_STAGES-1];
  assign pos_o   = pos_q[SQRT_STAGES-1];
  assign num_o   = num_q[SQRT_STAGES-1];
  assign len_o   = st_q[SQRT_STAGES-1].root;

endmodule

// File: sv/fls_div.sv
// Pipelined restoring divider: dot product over normal length gives intensity.
module fls_div import fls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pipe_ctl_t         ctl_i,
  input  logic              pos_i,
  input  logic [DIVD_W-1:0] num_i,
  input  logic [LEN_W-1:0]  len_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    inten_o
);

  typedef struct packed {
    logic [LEN_W:0]   rem;
    logic [Q_W-1:0]   dvd;
    logic [Q_W-1:0]   quo;
  } dvst_t;

  // One quotient bit: shift in a dividend bit, subtract if it fits.
  function automatic dvst_t dv_step(dvst_t a, logic [LEN_W-1:0] len);
    logic [LEN_W:0] r2;
    dvst_t          b;
    r2    = {a.rem[LEN_W-1:0], a.dvd[Q_W-1]};
    b.dvd = a.dvd << 1;
    if (r2 >= (LEN_W+1)'(len)) begin
      b.rem = r2 - (LEN_W+1)'(len);
      b.quo = {a.quo[Q_W-2:0], 1'b1};
    end else begin
      b.rem = r2;
      b.quo = {a.quo[Q_W-2:0], 1'b0};
    end
    return b;
  endfunction

  logic [DIV_STAGES-1:0] v_q;
  logic [DIV_STAGES-1:0] pos_q;
  logic [LEN_W-1:0]      len_q [DIV_STAGES];
  dvst_t                 st_q  [DIV_STAGES];
  dvst_t                 st_d  [DIV_STAGES];
  dvst_t                 init;

  // High dividend bits are below the length, so they seed the remainder.
  assign init.rem = (LEN_W+1)'(num_i >> Q_W);
  assign init.dvd = num_i[Q_W-1:0];
  assign init.quo = '0;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stg
    always_comb begin
      dvst_t            t;
      logic [LEN_W-1:0] l;
      t = (s == 0) ? init : st_q[(s == 0) ? 0 : s-1];
      l = (s == 0) ? len_i : len_q[(s == 0) ? 0 : s-1];
      for (int j = 0; j < DIV_PER_STG; j++) begin
        t = dv_step(t, l);
      end
      st_d[s] = t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      pos_q <= '0;
    end else if (ctl_i.en) begin
      v_q   <= {v_q[DIV_STAGES-2:0], ctl_i.valid};
      pos_q <= {pos_q[DIV_STAGES-2:0], pos_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      len_q[0] <= len_i;
      st_q[0]  <= st_d[0];
      for (int s = 1; s < DIV_STAGES; s++) begin
        len_q[s] <= len_q[s-1];
        st_q[s]  <= st_d[s];
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign inten_o = pos_q[DIV_STAGES-1] ? st_q[DIV_STAGES-1].quo : '0;

endmodule

// File: sv/fls_shade.sv
// Color scaling by intensity, ambient add and saturation; holds the output register.
module fls_shade import fls_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pipe_ctl_t          ctl_i,
  input  logic [Q_W-1:0]     inten_i,
  input  color_t             color_i,
  output logic               valid_o,
  output logic [COLOR_W-1:0] rgb_o [3]
);

  localparam int PRD_W = COLOR_W + Q_W;
  localparam int SUM_W = PRD_W - FRAC_BITS + 1;

  logic [SHADE_STAGES-1:0] v_q;
  logic [PRD_W-1:0]        prd_q [3];
  logic [COLOR_W-1:0]      rgb_q [3];
  logic [COLOR_W-1:0]      base  [3];

  assign base[0] = color_i.red;
  assign base[1] = color_i.green;
  assign base[2] = color_i.blue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.en) begin
      v_q <= {v_q[SHADE_STAGES-2:0], ctl_i.valid};
    end
  end

  // Multiply, then drop fraction, add ambient and clip.
  always_ff @(posedge clk_i) begin
    logic [SUM_W-1:0] sum;
    if (ctl_i.en) begin
      for (int k = 0; k < 3; k++) begin
        prd_q[k] <= PRD_W'(base[k]) * PRD_W'(inten_i);
        sum      = SUM_W'(prd_q[k] >> FRAC_BITS) + SUM_W'(color_i.ambient);
        rgb_q[k] <= (sum > SUM_W'(COLOR_MAX)) ? COLOR_MAX : sum[COLOR_W-1:0];
      end
    end
  end

  assign valid_o = v_q[SHADE_STAGES-1];
  assign rgb_o   = rgb_q;

endmodule

// File: sim/flat_lambert_triangle_shader_tb.sv
// Testbench for the flat Lambert triangle shader: random and directed triangles, checked per channel.
module flat_lambert_triangle_shader_tb;
  import fls_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z from bit 0 up
  logic [9*COORD_BITS-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // out_red, out_green, out_blue from bit 0 up
  logic [3*COLOR_W-1:0] m_axis_tdata_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  flat_lambert_triangle_shader i_dut (.*);

  localparam int LATENCY = 26;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [COLOR_W-1:0] red, green, blue;
  } pixel_t;

  // shading state mirrored from register writes
  logic signed [LIGHT_W-1:0] lx, ly, lz;
  logic [COLOR_W-1:0] b_red, b_green, b_blue, amb;

  pixel_t pixel_q[$];
  int mismatches = 0;
  int triangles = 0;
  int pixels = 0;
  int idle_cycles = 0;
  int light_writes = 0;
  bit rx_stall_on = 1'b1;

  initial forever #5 clk_i = ~clk_i;

  // watchdog: cycles with no completed transfer on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic longint sm_shr(longint x, int s);
    longint m;
    m = (x < 0) ? -x : x;
    if (s >= 0) m = (s >= 63) ? 0 : (m >>> s);
    else m = m <<< (-s);
    return (x < 0) ? -m : m;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic logic [COLOR_W-1:0] tint(logic [COLOR_W-1:0] base, longint inten);
    longint c;
    c = ((longint'(base) * inten) >>> FRAC_BITS) + longint'(amb);
    return (c > 255) ? COLOR_MAX : c[COLOR_W-1:0];
  endfunction

  function automatic pixel_t shade_triangle(logic [9*COORD_BITS-1:0] verts);
    longint v[9], e1[3], e2[3], n[3];
    longint mx, a, sq, len, d, inten;
    int top;
    pixel_t px;
    for (int i = 0; i < 9; i++)
      v[i] = longint'($signed(verts[i*COORD_BITS +: COORD_BITS]));
    for (int i = 0; i < 3; i++) begin
      e1[i] = sm_shr(v[3+i] - v[i], EDGE_SHIFT);
      e2[i] = sm_shr(v[6+i] - v[i], EDGE_SHIFT);
    end
    n[0] = e1[1]*e2[2] - e1[2]*e2[1];
    n[1] = e1[2]*e2[0] - e1[0]*e2[2];
    n[2] = e1[0]*e2[1] - e1[1]*e2[0];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      a = (n[i] < 0) ? -n[i] : n[i];
      if (a > mx) mx = a;
    end
    inten = 0;
    if (mx != 0) begin
      top = 62;
      while (((mx >>> top) & 1) == 0) top--;
      for (int i = 0; i < 3; i++) n[i] = sm_shr(n[i], top - NORM_TOP);
      sq = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
      len = floor_sqrt(sq);
      d = n[0]*longint'(lx) + n[1]*longint'(ly) + n[2]*longint'(lz);
      if (d > 0 && len != 0) inten = d / len;
    end
    px.red = tint(b_red, inten);
    px.green = tint(b_green, inten);
    px.blue = tint(b_blue, inten);
    return px;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // output side: random backpressure, compare against oldest expected pixel
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        stall--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (rx_stall_on) stall = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      pixels++;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h", m_axis_tdata_o);
      end else begin
        want = pixel_q.pop_front();
        if (m_axis_tdata_o[7:0] !== want.red || m_axis_tdata_o[15:8] !== want.green ||
            m_axis_tdata_o[23:16] !== want.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, m_axis_tdata_o[7:0],
                     m_axis_tdata_o[15:8], m_axis_tdata_o[23:16]);
        end
      end
    end
  end

  // one triangle request; prediction taken at acceptance
  task automatic send_triangle(logic [9*COORD_BITS-1:0] verts, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    repeat (g) @(negedge clk_i);
    s_axis_tdata_i = verts;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pixel_q.push_back(shade_triangle(verts));
    triangles++;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_addr_i = idx;
    cfg_data_i = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LIGHT_X: lx = val;
      CFG_LIGHT_Y: ly = val;
      CFG_LIGHT_Z: lz = val;
      CFG_BASE_RED: b_red = val[7:0];
      CFG_BASE_GREEN: b_green = val[7:0];
      CFG_BASE_BLUE: b_blue = val[7:0];
      CFG_AMBIENT: amb = val[7:0];
      default: ;
    endcase
    if (idx <= CFG_LIGHT_Z) light_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (pixel_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic set_shading(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    drain();
    write_reg(CFG_LIGHT_X, x);
    write_reg(CFG_LIGHT_Y, y);
    write_reg(CFG_LIGHT_Z, z);
    write_reg(CFG_BASE_RED, {8'd0, r});
    write_reg(CFG_BASE_GREEN, {8'd0, g});
    write_reg(CFG_BASE_BLUE, {8'd0, b});
    write_reg(CFG_AMBIENT, {8'd0, a});
  endtask

  function automatic logic [9*COORD_BITS-1:0] pack_tri(int c[9]);
    logic [9*COORD_BITS-1:0] t;
    for (int i = 0; i < 9; i++) t[i*COORD_BITS +: COORD_BITS] = COORD_BITS'(c[i]);
    return t;
  endfunction

  function automatic logic [9*COORD_BITS-1:0] random_tri();
    logic [9*COORD_BITS-1:0] t;
    int mode, span;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) t[i*COORD_BITS +: COORD_BITS] = COORD_BITS'($urandom);
    if (mode < 4) begin
      // small triangle around a random center
      span = 1 << $urandom_range(0, 12);
      for (int i = 3; i < 9; i++)
        t[i*COORD_BITS +: COORD_BITS] = COORD_BITS'(t[(i%3)*COORD_BITS +: COORD_BITS] +
                                        $urandom_range(0, 2*span) - span);
    end else if (mode == 4) begin
      // collinear: v2 = v1
      t[6*COORD_BITS +: 3*COORD_BITS] = t[3*COORD_BITS +: 3*COORD_BITS];
    end else if (mode == 5) begin
      for (int i = 0; i < 9; i++)
        t[i*COORD_BITS +: COORD_BITS] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    end
    return t;
  endfunction

  // directed extremes, degenerate faces and both facing directions
  task automatic test_directed();
    int c[9];
    set_shading(16'd0, 16'd0, 16'd16384, 8'd100, 8'd100, 8'd100, 8'd30);
    c = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};            send_triangle(pack_tri(c), 0);
    c = '{0, 0, 0, 0, 4096, 0, 4096, 0, 0};            send_triangle(pack_tri(c), 0);
    c = '{5, 5, 5, 5, 5, 5, 5, 5, 5};                  send_triangle(pack_tri(c), 0);
    c = '{0, 0, 0, 1, 1, 1, 2, 2, 2};                  send_triangle(pack_tri(c), 0);
    c = '{-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0};
    send_triangle(pack_tri(c), 0);
    c = '{32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768};
    send_triangle(pack_tri(c), 0);
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                  send_triangle(pack_tri(c), 0);
    c = '{-1, -1, -1, -32768, -1, -1, -1, -32768, -1}; send_triangle(pack_tri(c), 0);
    // light longer than unit, bright colors: saturation
    set_shading(16'h7fff, 16'h7fff, 16'h7fff, 8'd255, 8'd200, 8'd0, 8'd255);
    c = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};            send_triangle(pack_tri(c), 0);
    c = '{0, 0, 0, 4096, 4096, 0, 0, 4096, 4096};      send_triangle(pack_tri(c), 0);
    set_shading(16'h8000, 16'h8000, 16'h8000, 8'd255, 8'd255, 8'd255, 8'd0);
    c = '{0, 0, 0, 0, 4096, 0, 4096, 0, 0};            send_triangle(pack_tri(c), 0);
    c = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};            send_triangle(pack_tri(c), 0);
    c = '{0, 0, 0, -4096, 4096, 0, 0, 0, -4096};       send_triangle(pack_tri(c), 0);
  endtask

  // random triangles under several shading settings, idles on both sides
  task automatic test_random();
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_shading(16'd0, 16'd0, 16'd16384, 8'd100, 8'd100, 8'd100, 8'd30);
        1: set_shading(16'd9459, 16'd9459, 16'd9459, 8'd255, 8'd128, 8'd1, 8'd0);
        2: set_shading(16'h7fff, 16'h8000, 16'd0, 8'd0, 8'd255, 8'd77, 8'd255);
        default: set_shading(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom),
                             8'(($urandom_range(0, 3) == 0) ? $urandom : 0));
      endcase
      rx_stall_on = (phase != 3);
      for (int i = 0; i < 200; i++) send_triangle(random_tri(), phase != 4);
    end
  endtask

  initial begin
    lx = LIGHT_X_RST; ly = LIGHT_Y_RST; lz = LIGHT_Z_RST;
    b_red = BASE_RST; b_green = BASE_RST; b_blue = BASE_RST; amb = AMBIENT_RST;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    drain();
    $display("covered %0d triangles, %0d pixels checked, %0d light register writes",
             triangles, pixels, light_writes);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d pixels missing", mismatches, pixel_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// File: files.f
sv/fls_pkg.sv
sv/fls_norm.sv
sv/fls_sqrt.sv
sv/fls_div.sv
sv/fls_shade.sv
sv/flat_lambert_triangle_shader.sv
sim/flat_lambert_triangle_shader_tb.sv
